// File: hdl/lst2d_pkg.sv
`timescale 1ns / 1ps
package lst2d_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int MAX_ANCHORS = 16;
   localparam int SUM_WIDTH = 64;
   localparam int ACC_WIDTH = 128;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_TOO_FEW = 2'd1;
   localparam logic [1:0] STATUS_SINGULAR = 2'd2;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] anchor_x;
      logic signed [COORD_WIDTH-1:0] anchor_y;
      logic [COORD_WIDTH-2:0] range;
      logic anchor_valid;
      logic last_anchor;
   } req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] pos_x;
      logic signed [COORD_WIDTH-1:0] pos_y;
      logic [1:0] status;
   } rsp_type;

endpackage

// File: hdl/least_squares_trilateration_2d.sv
`timescale 1ns / 1ps
// an anchor that adds a row runs nine products in turn on one
// 32x32 multiplier, each as four partial products, an add step and a writeback step
// a last anchor adds the solve: six products and two 128-step restoring
// divisions; an anchor that adds no row starts no products of its own
// req_ready is high only while idle; one result waits in the output register
// synchronous reset clears the reference, row count and all sums
module least_squares_trilateration_2d #(
   parameter int MAX_ANCHORS = lst2d_pkg::MAX_ANCHORS
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  lst2d_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output lst2d_pkg::rsp_type rsp_data
);

   localparam int W = lst2d_pkg::COORD_WIDTH;
   localparam int SW = lst2d_pkg::SUM_WIDTH;
   localparam int AW = lst2d_pkg::ACC_WIDTH;
   localparam int RCW = $clog2(MAX_ANCHORS);

   // micro-op codes
   localparam logic [3:0] UOP_RR = 4'd0;
   localparam logic [3:0] UOP_DD = 4'd1;
   localparam logic [3:0] UOP_XS = 4'd2;
   localparam logic [3:0] UOP_YS = 4'd3;
   localparam logic [3:0] UOP_AXX = 4'd4;
   localparam logic [3:0] UOP_AXY = 4'd5;
   localparam logic [3:0] UOP_AYY = 4'd6;
   localparam logic [3:0] UOP_BX = 4'd7;
   localparam logic [3:0] UOP_BY = 4'd8;
   localparam logic [3:0] UOP_DET0 = 4'd9;
   localparam logic [3:0] UOP_DET1 = 4'd10;
   localparam logic [3:0] UOP_NX0 = 4'd11;
   localparam logic [3:0] UOP_NX1 = 4'd12;
   localparam logic [3:0] UOP_NY0 = 4'd13;
   localparam logic [3:0] UOP_NY1 = 4'd14;

   localparam logic [2:0] PART_WB = 3'd5;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_MAC   = 6'b000010,
      ST_CHECK = 6'b000100,
      ST_DIV   = 6'b001000,
      ST_FIN   = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   lst2d_pkg::req_type item_ff, item_in;
   logic [W-1:0] ref_x_ff, ref_x_in, ref_y_ff, ref_y_in;
   logic [W-2:0] ref_r_ff, ref_r_in;
   logic ref_taken_ff, ref_taken_in;
   logic [RCW-1:0] rc_ff, rc_in;
   logic [SW-1:0] xx_ff, xx_in, xy_ff, xy_in, yy_ff, yy_in, abx_ff, abx_in, aby_ff, aby_in;
   logic [SW-1:0] b_ff, b_in;
   logic [AW-1:0] acc_ff, acc_in;
   logic [3:0] uop_ff, uop_in;
   logic [2:0] part_ff, part_in;
   logic [63:0] prod_ff, prod_in;
   logic [1:0] pshift_ff, pshift_in;
   logic pneg_ff, pneg_in, padd_ff, padd_in;
   logic [AW-1:0] det_mag_ff, det_mag_in, num_ff, num_in, rem_ff, rem_in;
   logic det_neg_ff, det_neg_in, num_neg_ff, num_neg_in;
   logic [W:0] quo_ff, quo_in;
   logic ovf_ff, ovf_in, sel_y_ff, sel_y_in;
   logic [6:0] cnt_ff, cnt_in;
   logic [W-1:0] px_ff, px_in, py_ff, py_in;
   logic [1:0] status_ff, status_in;
   logic rsp_valid_ff, rsp_valid_in;
   lst2d_pkg::rsp_type rsp_ff, rsp_in;

   logic [SW-1:0] xj, yj, x1, y1, dj, r1, dx, dy, sx, sy, ax, ay;
   logic [SW-1:0] op_a, op_b, mag_a, mag_b;
   logic op_sub;
   logic [31:0] mul_a, mul_b;
   logic [AW-1:0] shifted, acc_abs, rs;
   logic ge;
   logic [W:0] limit, q_sat;
   logic [W-1:0] field;
   logic row_ok;

   assign xj = {{(SW-W){item_ff.anchor_x[W-1]}}, item_ff.anchor_x};
   assign yj = {{(SW-W){item_ff.anchor_y[W-1]}}, item_ff.anchor_y};
   assign x1 = {{(SW-W){ref_x_ff[W-1]}}, ref_x_ff};
   assign y1 = {{(SW-W){ref_y_ff[W-1]}}, ref_y_ff};
   assign dj = {{(SW-W+1){1'b0}}, item_ff.range};
   assign r1 = {{(SW-W+1){1'b0}}, ref_r_ff};
   assign dx = xj - x1;
   assign dy = yj - y1;
   assign sx = xj + x1;
   assign sy = yj + y1;
   assign ax = {dx[SW-2:0], 1'b0};
   assign ay = {dy[SW-2:0], 1'b0};

   always_comb begin
      op_a = r1;
      op_b = r1;
      op_sub = 1'b0;
      case (uop_ff)
         UOP_RR: begin op_a = r1; op_b = r1; end
         UOP_DD: begin op_a = dj; op_b = dj; op_sub = 1'b1; end
         UOP_XS: begin op_a = dx; op_b = sx; end
         UOP_YS: begin op_a = dy; op_b = sy; end
         UOP_AXX: begin op_a = ax; op_b = ax; end
         UOP_AXY: begin op_a = ax; op_b = ay; end
         UOP_AYY: begin op_a = ay; op_b = ay; end
         UOP_BX: begin op_a = ax; op_b = b_ff; end
         UOP_BY: begin op_a = ay; op_b = b_ff; end
         UOP_DET0: begin op_a = xx_ff; op_b = yy_ff; end
         UOP_DET1: begin op_a = xy_ff; op_b = xy_ff; op_sub = 1'b1; end
         UOP_NX0: begin op_a = yy_ff; op_b = abx_ff; end
         UOP_NX1: begin op_a = xy_ff; op_b = aby_ff; op_sub = 1'b1; end
         UOP_NY0: begin op_a = xx_ff; op_b = aby_ff; end
         UOP_NY1: begin op_a = xy_ff; op_b = abx_ff; op_sub = 1'b1; end
         default: begin op_a = r1; op_b = r1; end
      endcase
   end

   assign mag_a = op_a[SW-1] ? (~op_a + 1'b1) : op_a;
   assign mag_b = op_b[SW-1] ? (~op_b + 1'b1) : op_b;
   assign mul_a = part_ff[0] ? mag_a[63:32] : mag_a[31:0];
   assign mul_b = part_ff[1] ? mag_b[63:32] : mag_b[31:0];
   assign prod_in = {32'b0, mul_a} * {32'b0, mul_b};
   assign pshift_in = {1'b0, part_ff[0]} + {1'b0, part_ff[1]};
   assign pneg_in = op_a[SW-1] ^ op_b[SW-1] ^ op_sub;
   assign padd_in = (state_ff == ST_MAC) && (part_ff < 3'd4);
   assign shifted = {64'b0, prod_ff} << {pshift_ff, 5'b0};
   assign acc_abs = acc_ff[AW-1] ? (~acc_ff + 1'b1) : acc_ff;

   assign rs = {rem_ff[AW-2:0], num_ff[AW-1]};
   assign ge = rs >= det_mag_ff;
   assign limit = (num_neg_ff ^ det_neg_ff) ? (W+1)'(1) << (W-1)
                                             : ((W+1)'(1) << (W-1)) - 1'b1;
   assign q_sat = (ovf_ff || quo_ff > limit) ? limit : quo_ff;
   assign field = (num_neg_ff ^ det_neg_ff) ? W'(~q_sat + 1'b1) : W'(q_sat);
   assign row_ok = ref_taken_ff && (rc_ff < RCW'(MAX_ANCHORS - 1));

   always_comb begin
      state_in = state_ff;
      item_in = item_ff;
      ref_x_in = ref_x_ff;
      ref_y_in = ref_y_ff;
      ref_r_in = ref_r_ff;
      ref_taken_in = ref_taken_ff;
      rc_in = rc_ff;
      xx_in = xx_ff;
      xy_in = xy_ff;
      yy_in = yy_ff;
      abx_in = abx_ff;
      aby_in = aby_ff;
      b_in = b_ff;
      acc_in = padd_ff ? acc_ff + (pneg_ff ? (~shifted + 1'b1) : shifted) : acc_ff;
      uop_in = uop_ff;
      part_in = part_ff;
      det_mag_in = det_mag_ff;
      det_neg_in = det_neg_ff;
      num_in = num_ff;
      num_neg_in = num_neg_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      ovf_in = ovf_ff;
      sel_y_in = sel_y_ff;
      cnt_in = cnt_ff;
      px_in = px_ff;
      py_in = py_ff;
      status_in = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in = req_data;
               px_in = '0;
               py_in = '0;
               state_in = req_data.last_anchor ? ST_CHECK : ST_IDLE;
               if (req_data.anchor_valid) begin
                  if (!ref_taken_ff) begin
                     ref_x_in = req_data.anchor_x;
                     ref_y_in = req_data.anchor_y;
                     ref_r_in = req_data.range;
                     ref_taken_in = 1'b1;
                  end else if (row_ok) begin
                     acc_in = '0;
                     uop_in = UOP_RR;
                     part_in = '0;
                     state_in = ST_MAC;
                  end
               end
            end
         end
         ST_MAC: begin
            if (part_ff != PART_WB) begin
               part_in = part_ff + 1'b1;
            end else begin
               part_in = '0;
               uop_in = uop_ff + 1'b1;
               case (uop_ff)
                  UOP_YS: begin b_in = acc_ff[SW-1:0]; acc_in = {64'b0, xx_ff}; end
                  UOP_AXX: begin xx_in = acc_ff[SW-1:0]; acc_in = {64'b0, xy_ff}; end
                  UOP_AXY: begin xy_in = acc_ff[SW-1:0]; acc_in = {64'b0, yy_ff}; end
                  UOP_AYY: begin yy_in = acc_ff[SW-1:0]; acc_in = {64'b0, abx_ff}; end
                  UOP_BX: begin abx_in = acc_ff[SW-1:0]; acc_in = {64'b0, aby_ff}; end
                  UOP_BY: begin
                     aby_in = acc_ff[SW-1:0];
                     rc_in = rc_ff + 1'b1;
                     state_in = item_ff.last_anchor ? ST_CHECK : ST_IDLE;
                  end
                  UOP_DET1: begin
                     det_mag_in = acc_abs;
                     det_neg_in = acc_ff[AW-1];
                     acc_in = '0;
                     if (acc_ff == '0) begin
                        status_in = lst2d_pkg::STATUS_SINGULAR;
                        state_in = ST_DONE;
                     end
                  end
                  UOP_NX1, UOP_NY1: begin
                     num_in = acc_abs;
                     num_neg_in = acc_ff[AW-1];
                     rem_in = '0;
                     quo_in = '0;
                     ovf_in = 1'b0;
                     cnt_in = '0;
                     sel_y_in = (uop_ff == UOP_NY1);
                     state_in = ST_DIV;
                  end
                  default: ;
               endcase
            end
         end
         ST_CHECK: begin
            if (rc_ff < RCW'(2)) begin
               status_in = lst2d_pkg::STATUS_TOO_FEW;
               state_in = ST_DONE;
            end else begin
               acc_in = '0;
               uop_in = UOP_DET0;
               part_in = '0;
               state_in = ST_MAC;
            end
         end
         ST_DIV: begin
            num_in = {num_ff[AW-2:0], 1'b0};
            rem_in = ge ? rs - det_mag_ff : rs;
            quo_in = {quo_ff[W-1:0], ge};
            ovf_in = ovf_ff | quo_ff[W];
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 7'(AW - 1)) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (sel_y_ff) begin
               py_in = field;
               status_in = lst2d_pkg::STATUS_OK;
               state_in = ST_DONE;
            end else begin
               px_in = field;
               acc_in = '0;
               uop_in = UOP_NY0;
               part_in = '0;
               state_in = ST_MAC;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in.pos_x = (status_ff == lst2d_pkg::STATUS_OK) ? px_ff : '0;
               rsp_in.pos_y = (status_ff == lst2d_pkg::STATUS_OK) ? py_ff : '0;
               rsp_in.status = status_ff;
               ref_x_in = '0;
               ref_y_in = '0;
               ref_r_in = '0;
               ref_taken_in = 1'b0;
               rc_in = '0;
               xx_in = '0;
               xy_in = '0;
               yy_in = '0;
               abx_in = '0;
               aby_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ref_x_ff <= '0;
         ref_y_ff <= '0;
         ref_r_ff <= '0;
         ref_taken_ff <= 1'b0;
         rc_ff <= '0;
         xx_ff <= '0;
         xy_ff <= '0;
         yy_ff <= '0;
         abx_ff <= '0;
         aby_ff <= '0;
         padd_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         uop_ff <= '0;
         part_ff <= '0;
      end else begin
         state_ff <= state_in;
         ref_x_ff <= ref_x_in;
         ref_y_ff <= ref_y_in;
         ref_r_ff <= ref_r_in;
         ref_taken_ff <= ref_taken_in;
         rc_ff <= rc_in;
         xx_ff <= xx_in;
         xy_ff <= xy_in;
         yy_ff <= yy_in;
         abx_ff <= abx_in;
         aby_ff <= aby_in;
         padd_ff <= padd_in;
         rsp_valid_ff <= rsp_valid_in;
         uop_ff <= uop_in;
         part_ff <= part_in;
      end
      item_ff <= item_in;
      b_ff <= b_in;
      acc_ff <= acc_in;
      prod_ff <= prod_in;
      pshift_ff <= pshift_in;
      pneg_ff <= pneg_in;
      det_mag_ff <= det_mag_in;
      det_neg_ff <= det_neg_in;
      num_ff <= num_in;
      num_neg_ff <= num_neg_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
      sel_y_ff <= sel_y_in;
      cnt_ff <= cnt_in;
      px_ff <= px_in;
      py_ff <= py_in;
      status_ff <= status_in;
      rsp_ff <= rsp_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != lst2d_pkg::STATUS_OK
         |-> rsp_ff.pos_x == '0 && rsp_ff.pos_y == '0)
      else $error("failed solve with nonzero position");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.anchor_valid && row_ok |=> !req_ready)
      else $error("ready while a row is in progress");

   a_rc_bound: assert property (@(posedge clock) disable iff (reset)
      rc_ff <= RCW'(MAX_ANCHORS - 1))
      else $error("row count past limit");

   a_add_in_mac: assert property (@(posedge clock) disable iff (reset)
      padd_ff |-> state_ff == ST_MAC)
      else $error("partial product add outside multiply");

endmodule
